/* src/keyed_quantity_table_macros.svh */
// -----------------------------------------------------------------------------
// keyed_quantity_table_macros.svh
// Assertion shorthands shared by the keyed quantity table RTL.
// -----------------------------------------------------------------------------
`ifndef KEYED_QUANTITY_TABLE_MACROS_SVH
`define KEYED_QUANTITY_TABLE_MACROS_SVH

// Condition holds at every clock edge outside reset
`define KQT_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define KQT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle
`define KQT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/kqt_pkg.sv */
// -----------------------------------------------------------------------------
// kqt_pkg
// Types and constants shared by the keyed quantity table cells and top level.
// -----------------------------------------------------------------------------
`default_nettype none

package kqt_pkg;

   localparam int unsigned KEY_W  = 32;
   localparam int unsigned QTY_W  = 32;
   localparam int unsigned SLOT_W = 7;

   // Request codes
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_CHANGE = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Item travelling down the row of cells
   typedef struct packed {
      logic                     valid;
      req_kind_type             op;
      logic [KEY_W-1:0]         key;
      logic signed [QTY_W-1:0]  amount;
      logic                     full;   // insert refused at entry, cells ignore it
      logic                     hit;    // key matched a filled entry
      logic                     wrote;  // insert appended a new entry
      logic signed [QTY_W-1:0]  qty;
      logic [SLOT_W-1:0]        slot;
   } token_type;

endpackage

`default_nettype wire

/* src/kqt_cell.sv */
// -----------------------------------------------------------------------------
// kqt_cell
// One table entry: holds a key and quantity, checks the passing item against
// them, applies inserts and quantity changes, hands the item to the next cell.
// -----------------------------------------------------------------------------
`default_nettype none

module kqt_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] entry_count,
   input  wire kqt_pkg::token_type tok_in,
   output      kqt_pkg::token_type tok_out
);

   import kqt_pkg::*;

   localparam logic [CNT_W-1:0]  MY_INDEX = CNT_W'(INDEX);
   localparam logic [SLOT_W-1:0] MY_SLOT  = SLOT_W'(INDEX);

   logic [KEY_W-1:0]        key_ff,  key_in;
   logic signed [QTY_W-1:0] qty_ff,  qty_in;
   token_type               tok_ff,  tok_in_next;
   logic                    live;
   logic                    match;
   logic                    append;
   logic signed [QTY_W-1:0] sum_sat;

   // Saturating signed add
   function automatic logic signed [QTY_W-1:0] sat_add(
      input logic signed [QTY_W-1:0] a,
      input logic signed [QTY_W-1:0] b
   );
      logic signed [QTY_W:0] s;
      s = {a[QTY_W-1], a} + {b[QTY_W-1], b};
      if (s[QTY_W] != s[QTY_W-1]) begin
         sat_add = s[QTY_W] ? {1'b1, {(QTY_W-1){1'b0}}} : {1'b0, {(QTY_W-1){1'b1}}};
      end else begin
         sat_add = s[QTY_W-1:0];
      end
   endfunction

   // Entry checks: only filled entries are compared, first match wins
   assign live    = tok_in.valid && !tok_in.full && !tok_in.hit && !tok_in.wrote;
   assign match   = live && (MY_INDEX < entry_count) && (key_ff == tok_in.key);
   assign append  = live && (tok_in.op == REQ_INSERT) && (MY_INDEX == entry_count);
   assign sum_sat = sat_add(qty_ff, tok_in.amount);

   // Next entry contents and outgoing item
   always_comb begin
      key_in      = key_ff;
      qty_in      = qty_ff;
      tok_in_next = tok_in;
      if (append) begin
         key_in            = tok_in.key;
         qty_in            = tok_in.amount;
         tok_in_next.wrote = 1'b1;
         tok_in_next.qty   = tok_in.amount;
         tok_in_next.slot  = MY_SLOT;
      end else if (match) begin
         tok_in_next.hit  = 1'b1;
         tok_in_next.slot = MY_SLOT;
         if (tok_in.op == REQ_CHANGE) begin
            qty_in          = sum_sat;
            tok_in_next.qty = sum_sat;
         end else begin
            tok_in_next.qty = qty_ff;
         end
      end
   end

   // Entry storage, undefined until written
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      qty_ff <= qty_in;
   end

   // Hand-off register to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

/* src/keyed_quantity_table.sv */
// Each item walks the row of CAPACITY entry cells one cell per cycle, with one
// item in the row at a time; a new request is stalled until the last one has
// left the tail for the output register.
// A request of the unused type is accepted and gives no result.
// Reset clears the entry count and all handshake state; entry contents are
// left undefined and are never read before being written (no clearing pass).
// -----------------------------------------------------------------------------
// keyed_quantity_table
// Keyed table of part numbers and signed quantities with insert, search and
// saturating quantity change, built as a row of entry cells.
// -----------------------------------------------------------------------------
`default_nettype none

module keyed_quantity_table #(
   parameter int unsigned CAPACITY = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_part_number,
   input  wire logic [31:0] req_amount,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [1:0]  rsp_status,
   output      logic [31:0] rsp_quantity,
   output      logic [6:0]  rsp_slot
);

   import kqt_pkg::*;

   `include "keyed_quantity_table_macros.svh"

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   token_type               link [0:CAPACITY];
   token_type               row_head;
   logic                    req_accept;
   req_kind_type            req_op;
   logic                    busy_ff,        busy_in;
   logic [CNT_W-1:0]        entry_count_ff, entry_count_in;
   logic                    tail_valid_ff,  tail_valid_in;
   token_type               tail_ff;
   logic                    move;
   logic                    rsp_valid_ff,   rsp_valid_in;
   status_type              rsp_status_ff,  rsp_status_in;
   logic signed [QTY_W-1:0] rsp_quantity_ff, rsp_quantity_in;
   logic [SLOT_W-1:0]       rsp_slot_ff,    rsp_slot_in;

   // Input handshake: one item in flight until its result leaves the tail
   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign req_op     = req_kind_type'(req_type);

   // Item entering the row
   always_comb begin
      row_head        = '0;
      row_head.valid  = req_accept && (req_op != REQ_UNUSED);
      row_head.op     = req_op;
      row_head.key    = req_part_number;
      row_head.amount = req_amount;
      row_head.full   = (req_op == REQ_INSERT) && (entry_count_ff == CAP_COUNT);
   end

   assign link[0] = row_head;

   // Row of entry cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kqt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .entry_count (entry_count_ff),
         .tok_in      (link[i]),
         .tok_out     (link[i+1])
      );
   end

   // Busy flag, entry count and tail hand-over
   assign move = tail_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      busy_in        = busy_ff;
      entry_count_in = entry_count_ff;
      tail_valid_in  = tail_valid_ff;
      if (link[0].valid) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end
      if (link[CAPACITY].valid) begin
         tail_valid_in = 1'b1;
         if (link[CAPACITY].wrote) begin
            entry_count_in = entry_count_ff + CNT_W'(1);
         end
      end else if (move) begin
         tail_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         entry_count_ff <= '0;
         tail_valid_ff  <= 1'b0;
      end else begin
         busy_ff        <= busy_in;
         entry_count_ff <= entry_count_in;
         tail_valid_ff  <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (link[CAPACITY].valid) begin
         tail_ff <= link[CAPACITY];
      end
   end

   // Result decode from the finished item
   always_comb begin
      rsp_status_in   = ST_NOT_FOUND;
      rsp_quantity_in = '0;
      rsp_slot_in     = '0;
      if (tail_ff.full) begin
         rsp_status_in = ST_FULL;
      end else if (tail_ff.wrote) begin
         rsp_status_in   = ST_OK;
         rsp_quantity_in = tail_ff.qty;
         rsp_slot_in     = tail_ff.slot;
      end else if (tail_ff.hit) begin
         rsp_status_in   = (tail_ff.op == REQ_INSERT) ? ST_DUPLICATE : ST_OK;
         rsp_quantity_in = tail_ff.qty;
         rsp_slot_in     = tail_ff.slot;
      end
   end

   // Output register
   always_comb begin
      if (move) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_quantity_ff <= rsp_quantity_in;
         rsp_slot_ff     <= rsp_slot_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_quantity = rsp_quantity_ff;
   assign rsp_slot     = rsp_slot_ff;

   // Checks
   `KQT_ASSERT_ALWAYS(a_count_in_range, clock, reset, entry_count_ff <= CAP_COUNT, "entry count above capacity")
   `KQT_ASSERT_SAME(a_row_end_busy, clock, reset, link[CAPACITY].valid, busy_ff && !tail_valid_ff, "item left the row while idle or with tail occupied")
   `KQT_ASSERT_NEXT(a_accept_busy, clock, reset, link[0].valid, busy_ff, "accepted item did not mark block busy")
   `KQT_ASSERT_SAME(a_tail_busy, clock, reset, tail_valid_ff, busy_ff, "tail holds an item while block idle")

endmodule

`default_nettype wire
